// ===== rtl/bpbd_pkg.sv =====
`default_nettype none
package bpbd_pkg;

	// field and register widths
	localparam int LEN_W = 3;
	localparam int DUR_W = 16;
	localparam int IDX_W = 3;
	localparam int DBC_W = 8;

	// defaults for the top level parameters
	localparam int NUM_BUTTONS_DEF = 5;
	localparam int MAX_PHASES_DEF  = 6;

	// configuration bus
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DURATION_0     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_MAX   = 3'd7;

	// reset values
	localparam logic [LEN_W-1:0] RESET_LENGTH   = 3'd2;
	localparam logic [DUR_W-1:0] RESET_DURATION = 16'd200;
	localparam logic [DBC_W-1:0] RESET_DEBOUNCE = 8'd5;

	// settings shared by the blink and debounce units
	typedef struct packed {
		logic [LEN_W-1:0] pattern_length;
		logic [DBC_W-1:0] debounce_max;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/bpbd_regs.sv =====
`default_nettype none
module bpbd_regs #(
	parameter int MAX_PHASES = 6
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [bpbd_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire  [bpbd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [bpbd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output bpbd_pkg::cfg_t                   cfg,
	output logic [bpbd_pkg::DUR_W-1:0]       durations [MAX_PHASES]
);
	import bpbd_pkg::*;

	logic [LEN_W-1:0]     length_q;
	logic [DBC_W-1:0]     debounce_q;
	logic [DUR_W-1:0]     dur_q [MAX_PHASES];
	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[APB_ADDR_W-1:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q   <= RESET_LENGTH;
			debounce_q <= RESET_DEBOUNCE;
			for (int i = 0; i < MAX_PHASES; i++) begin
				dur_q[i] <= RESET_DURATION;
			end
		end else if (wr_en) begin
			if (reg_idx == REG_PATTERN_LENGTH) begin
				length_q <= pwdata[LEN_W-1:0];
			end
			if (reg_idx == REG_DEBOUNCE_MAX) begin
				debounce_q <= pwdata[DBC_W-1:0];
			end
			for (int i = 0; i < MAX_PHASES; i++) begin
				if (reg_idx == REG_DURATION_0 + REG_IDX_W'(i)) begin
					dur_q[i] <= pwdata[DUR_W-1:0];
				end
			end
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (reg_idx == REG_PATTERN_LENGTH) begin
			prdata = APB_DATA_W'(length_q);
		end
		if (reg_idx == REG_DEBOUNCE_MAX) begin
			prdata = APB_DATA_W'(debounce_q);
		end
		for (int i = 0; i < MAX_PHASES; i++) begin
			if (reg_idx == REG_DURATION_0 + REG_IDX_W'(i)) begin
				prdata = APB_DATA_W'(dur_q[i]);
			end
		end
	end

	assign cfg.pattern_length = length_q;
	assign cfg.debounce_max   = debounce_q;
	assign durations          = dur_q;

endmodule
`default_nettype wire

// ===== rtl/bpbd_blink.sv =====
`default_nettype none
module bpbd_blink #(
	parameter int MAX_PHASES = 6
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         fire,
	input  bpbd_pkg::cfg_t              cfg,
	input  wire  [bpbd_pkg::DUR_W-1:0]  durations [MAX_PHASES],
	output logic                        led_level_s2,
	output logic                        led_toggled_s2
);
	import bpbd_pkg::*;

	logic [DUR_W-1:0] countdown_q;
	logic [IDX_W-1:0] index_q;
	logic             led_q;
	logic [DUR_W-1:0] dec;
	logic [LEN_W-1:0] active_len;
	logic [IDX_W:0]   inc;
	logic [IDX_W-1:0] next_idx;
	logic             expire;

	// clamp the pattern length into 1..MAX_PHASES
	always_comb begin
		if (cfg.pattern_length == '0) begin
			active_len = LEN_W'(1);
		end else if (cfg.pattern_length > LEN_W'(MAX_PHASES)) begin
			active_len = LEN_W'(MAX_PHASES);
		end else begin
			active_len = cfg.pattern_length;
		end
	end

	// countdown and phase advance
	assign dec      = countdown_q - DUR_W'(1);
	assign expire   = (dec == '0);
	assign inc      = {1'b0, index_q} + (IDX_W+1)'(1);
	assign next_idx = (inc >= (IDX_W+1)'(active_len)) ? '0 : inc[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= RESET_DURATION;
			index_q     <= '0;
			led_q       <= 1'b0;
		end else if (fire) begin
			if (expire) begin
				countdown_q <= durations[next_idx];
				index_q     <= next_idx;
				led_q       <= ~led_q;
			end else begin
				countdown_q <= dec;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fire) begin
			led_level_s2   <= led_q ^ expire;
			led_toggled_s2 <= expire;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bpbd_debounce.sv =====
`default_nettype none
module bpbd_debounce #(
	parameter int NUM_BUTTONS = 5
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     fire,
	input  bpbd_pkg::cfg_t          cfg,
	input  wire  [NUM_BUTTONS-1:0]  levels_s1,
	output logic [NUM_BUTTONS-1:0]  press_s2,
	output logic                    wake_s2
);
	import bpbd_pkg::*;

	logic [DBC_W-1:0]       count_q  [NUM_BUTTONS];
	logic [DBC_W-1:0]       count_nx [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0] press;

	// per button up/down integrator
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			count_nx[i] = count_q[i];
			press[i]    = 1'b0;
			if (levels_s1[i]) begin
				if (count_q[i] < cfg.debounce_max) begin
					count_nx[i] = count_q[i] + DBC_W'(1);
					press[i]    = (count_nx[i] == cfg.debounce_max);
				end
			end else if (count_q[i] != '0) begin
				count_nx[i] = count_q[i] - DBC_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				count_q[i] <= '0;
			end
		end else if (fire) begin
			count_q <= count_nx;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fire) begin
			press_s2 <= press;
			wake_s2  <= |press;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/blink_pattern_and_button_debounce.sv =====
// an accepted item moves from the input register to the result register on m_tdata
// throughput: one item per cycle unless stalled; the input register, the state update
//   with its result register, and the output handshake form a two-stage pipeline
// reset: asynchronous, active low; config registers take their default values,
//   the blink countdown starts at 200 ticks and all debounce counters at zero
`default_nettype none
module blink_pattern_and_button_debounce #(
	parameter int NUM_BUTTONS = bpbd_pkg::NUM_BUTTONS_DEF,
	parameter int MAX_PHASES  = bpbd_pkg::MAX_PHASES_DEF,
	parameter int IN_W        = ((NUM_BUTTONS + 7) / 8) * 8,
	parameter int OUT_W       = ((NUM_BUTTONS + 3 + 7) / 8) * 8
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// config port
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [bpbd_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire  [bpbd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [bpbd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	// input items
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [IN_W-1:0]                  s_tdata,  // button_levels
	// result items
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [OUT_W-1:0]                 m_tdata   // led_level, led_toggled,
	                                                   // press_events, wake
);
	import bpbd_pkg::*;

	cfg_t                   cfg;
	logic [DUR_W-1:0]       durations [MAX_PHASES];
	logic                   valid_s1;
	logic                   valid_s2;
	logic [NUM_BUTTONS-1:0] levels_s1;
	logic                   advance;
	logic                   fire;
	logic                   led_level_s2;
	logic                   led_toggled_s2;
	logic [NUM_BUTTONS-1:0] press_s2;
	logic                   wake_s2;

	bpbd_regs #(
		.MAX_PHASES(MAX_PHASES)
	) u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cfg      (cfg),
		.durations(durations)
	);

	// pipeline control
	assign advance  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			levels_s1 <= s_tdata[NUM_BUTTONS-1:0];
		end
	end

	bpbd_blink #(
		.MAX_PHASES(MAX_PHASES)
	) u_blink (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.cfg           (cfg),
		.durations     (durations),
		.led_level_s2  (led_level_s2),
		.led_toggled_s2(led_toggled_s2)
	);

	bpbd_debounce #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_debounce (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.cfg      (cfg),
		.levels_s1(levels_s1),
		.press_s2 (press_s2),
		.wake_s2  (wake_s2)
	);

	// result packing
	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_W'({wake_s2, press_s2, led_toggled_s2, led_level_s2});

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

// one result item of the block, led level in bit 0
typedef struct packed {
	logic       wake;
	logic [4:0] presses;
	logic       toggled;
	logic       led;
} tick_result_t;

// predicts the led and press outputs of every accepted tick and checks them
class blink_press_predictor;
	localparam int PHASES  = bpbd_pkg::MAX_PHASES_DEF;
	localparam int BUTTONS = bpbd_pkg::NUM_BUTTONS_DEF;

	// register copies
	logic [bpbd_pkg::LEN_W-1:0] pattern_len;
	logic [bpbd_pkg::DUR_W-1:0] durations[PHASES];
	logic [bpbd_pkg::DBC_W-1:0] press_limit;

	// blink and integrator state
	logic [bpbd_pkg::DUR_W-1:0] countdown;
	logic [bpbd_pkg::IDX_W-1:0] phase;
	logic                       led;
	logic [bpbd_pkg::DBC_W-1:0] integ[BUTTONS];

	tick_result_t expected_ticks[$];
	int mismatches;
	int ticks_checked;
	int toggles_checked;
	int presses_checked;

	function new();
		pattern_len = bpbd_pkg::RESET_LENGTH;
		foreach (durations[k]) durations[k] = bpbd_pkg::RESET_DURATION;
		press_limit = bpbd_pkg::RESET_DEBOUNCE;
		countdown = bpbd_pkg::RESET_DURATION;
		phase = '0;
		led = 1'b0;
		foreach (integ[k]) integ[k] = '0;
		mismatches = 0;
		ticks_checked = 0;
		toggles_checked = 0;
		presses_checked = 0;
	endfunction

	// a register write touches only the settings
	function void write_setting(logic [bpbd_pkg::REG_IDX_W-1:0] idx, logic [31:0] value);
		if (idx == bpbd_pkg::REG_PATTERN_LENGTH)
			pattern_len = value[bpbd_pkg::LEN_W-1:0];
		else if (idx == bpbd_pkg::REG_DEBOUNCE_MAX)
			press_limit = value[bpbd_pkg::DBC_W-1:0];
		else if (idx >= bpbd_pkg::REG_DURATION_0 && idx < bpbd_pkg::REG_DURATION_0 + PHASES)
			durations[idx - bpbd_pkg::REG_DURATION_0] = value[bpbd_pkg::DUR_W-1:0];
	endfunction

	// one timer tick: blink countdown, then the button integrators
	function void note_tick(logic [4:0] levels);
		tick_result_t r;
		int active;
		logic [bpbd_pkg::IDX_W-1:0] nxt;
		r = '0;
		countdown = countdown - 1'b1;
		if (countdown == '0) begin
			if (pattern_len == 0)
				active = 1;
			else if (pattern_len > PHASES)
				active = PHASES;
			else
				active = pattern_len;
			nxt = phase + 1'b1;
			if (nxt >= active)
				nxt = '0;
			phase = nxt;
			countdown = durations[nxt];
			led = ~led;
			r.toggled = 1'b1;
		end
		for (int b = 0; b < BUTTONS; b++) begin
			if (levels[b]) begin
				if (integ[b] < press_limit) begin
					integ[b] = integ[b] + 1'b1;
					if (integ[b] == press_limit)
						r.presses[b] = 1'b1;
				end
			end else if (integ[b] != 0) begin
				integ[b] = integ[b] - 1'b1;
			end
		end
		r.led = led;
		r.wake = |r.presses;
		expected_ticks.push_back(r);
	endfunction

	task report_mismatch(string msg);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	// compare one result item with the oldest expected tick
	task check_tick(logic [7:0] word);
		tick_result_t got;
		tick_result_t want;
		got = word;
		if (expected_ticks.size() == 0) begin
			report_mismatch($sformatf("result %02h with no tick pending", word));
			return;
		end
		want = expected_ticks.pop_front();
		ticks_checked++;
		if (want.toggled) toggles_checked++;
		if (want.wake) presses_checked++;
		if (got.led !== want.led)
			report_mismatch($sformatf("led_level %b, expected %b", got.led, want.led));
		if (got.toggled !== want.toggled)
			report_mismatch($sformatf("led_toggled %b, expected %b",
				got.toggled, want.toggled));
		if (got.presses !== want.presses)
			report_mismatch($sformatf("press_events %05b, expected %05b",
				got.presses, want.presses));
		if (got.wake !== want.wake)
			report_mismatch($sformatf("wake %b, expected %b", got.wake, want.wake));
	endtask

	function int pending();
		return expected_ticks.size();
	endfunction
endclass

module tb_top;
	import bpbd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;  // button_levels
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;       // led_level, led_toggled, press_events, wake

	blink_pattern_and_button_debounce dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	blink_press_predictor board;

	// handshakes seen at the coming rising edge, settled since the falling one
	logic       in_taken = 1'b0;
	logic       out_taken = 1'b0;
	logic       reg_taken = 1'b0;
	logic [7:0] out_word = '0;

	// idling control
	bit no_idle = 1'b0;
	int holds_asked = 0;
	int holds_granted = 0;
	int hold_left = 0;
	int settings_used = 0;

	// button sequence generator: held levels with bounce and some noise
	logic btn_held[5];
	int   btn_run[5];
	int   run_max = 8;
	int   bounce_pct = 10;
	int   noise_pct = 20;

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		in_taken <= s_tvalid && s_tready;
		out_taken <= m_tvalid && m_tready;
		out_word <= m_tdata;
		reg_taken <= psel && penable && pwrite && pready;
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_granted != holds_asked) begin
			m_tready <= 1'b0;
			hold_left <= 300;
			holds_granted <= holds_granted + 1;
		end else begin
			m_tready <= no_idle || ($urandom_range(99) >= 36);
		end
	end

	// result checking
	always @(posedge clk) begin
		if (out_taken === 1'b1)
			board.check_tick(out_word);
	end

	function automatic logic [4:0] next_levels();
		logic [4:0] lv;
		if ($urandom_range(99) < noise_pct)
			return 5'($urandom_range(31));
		for (int b = 0; b < 5; b++) begin
			if (btn_run[b] <= 0) begin
				btn_held[b] = 1'($urandom_range(1));
				btn_run[b] = $urandom_range(1, run_max);
			end
			btn_run[b]--;
			lv[b] = ($urandom_range(99) < bounce_pct) ? ~btn_held[b] : btn_held[b];
		end
		return lv;
	endfunction

	task automatic send_tick(input logic [4:0] levels);
		if (!no_idle && $urandom_range(99) < 36) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 36);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, levels};
		do @(posedge clk); while (!in_taken);
		board.note_tick(levels);
	endtask

	task automatic run_ticks(input int count);
		repeat (count) send_tick(next_levels());
		s_tvalid <= 1'b0;
	endtask

	// wait until every result is in and the pipeline has emptied
	task automatic settle();
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// bus is left in the access state; the caller releases it
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!reg_taken);
		board.write_setting(idx, value);
	endtask

	task automatic set_pattern(input logic [LEN_W-1:0] len, input logic [5:0][DUR_W-1:0] dur,
			input logic [DBC_W-1:0] limit);
		settle();
		write_reg(REG_PATTERN_LENGTH, 32'(len));
		for (int k = 0; k < 6; k++)
			write_reg(REG_DURATION_0 + REG_IDX_W'(k), 32'(dur[k]));
		write_reg(REG_DEBOUNCE_MAX, 32'(limit));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		settings_used++;
		foreach (btn_run[b]) btn_run[b] = 0;
	endtask

	function automatic logic [5:0][DUR_W-1:0] short_durations(input int hi);
		logic [5:0][DUR_W-1:0] d;
		for (int k = 0; k < 6; k++)
			d[k] = DUR_W'($urandom_range(1, hi));
		return d;
	endfunction

	// main sequence
	initial begin
		logic [4:0] opening[$];
		logic [5:0][DUR_W-1:0] d;
		logic [DBC_W-1:0] lim;
		opening = {5'h1f, 5'h1f, 5'h1f, 5'h1f, 5'h1f, 5'h1f, 5'h00, 5'h1f,
			5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10,
			5'h15, 5'h0a, 5'h15, 5'h0a};
		board = new();
		foreach (btn_run[b]) begin
			btn_run[b] = 0;
			btn_held[b] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every button hits the limit, then single buttons
		foreach (opening[i]) send_tick(opening[i]);
		s_tvalid <= 1'b0;

		// shortest pattern, one-tick debounce; once the running phase ends
		// the led toggles on every tick
		d = '{default: 16'd1};
		set_pattern(3'd1, d, 8'd1);
		run_max = 6; bounce_pct = 10; noise_pct = 20;
		run_ticks(200);

		// full pattern, largest debounce limit with long holds
		d = short_durations(9);
		set_pattern(3'd6, d, 8'd255);
		run_max = 700; bounce_pct = 1; noise_pct = 3;
		run_ticks(500);

		// shorter pattern and a lowered limit over high counters, no idling
		d = short_durations(20);
		set_pattern(3'd3, d, 8'd3);
		run_max = 12; bounce_pct = 10; noise_pct = 20;
		no_idle = 1'b1;
		run_ticks(250);
		no_idle = 1'b0;

		// length zero behaves as one, limit zero never reports
		d = short_durations(6);
		set_pattern(3'd0, d, 8'd0);
		run_max = 8;
		run_ticks(150);

		// length seven behaves as six
		d = short_durations(12);
		lim = DBC_W'($urandom_range(2, 20));
		set_pattern(3'd7, d, lim);
		run_max = 2 * lim + 10; bounce_pct = 8;
		run_ticks(250);

		// unused phase holds the largest duration; receiver holds off for a while
		d = short_durations(10);
		d[5] = 16'hffff;
		set_pattern(3'd2, d, 8'd4);
		run_max = 14; bounce_pct = 10;
		holds_asked = holds_asked + 1;
		run_ticks(300);

		// a zero-length phase wraps the countdown and the led stays put
		d = short_durations(10);
		d[0] = 16'd3;
		d[1] = 16'd0;
		set_pattern(3'd2, d, 8'd8);
		run_max = 20;
		run_ticks(200);

		// drain
		while (board.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (board.pending() != 0)
			board.report_mismatch($sformatf("%0d results never arrived", board.pending()));
		$display("covered %0d ticks over %0d register settings plus reset defaults",
			board.ticks_checked, settings_used);
		$display("checked %0d led toggles and %0d ticks with button presses",
			board.toggles_checked, board.presses_checked);
		if (board.mismatches == 0) begin
			$display("blink_pattern_and_button_debounce verification clean");
		end else begin
			$display("blink_pattern_and_button_debounce verification failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", board.pending());
		$display("blink_pattern_and_button_debounce verification failed");
		$finish;
	end

endmodule

// ===== blink_pattern_and_button_debounce.f =====
rtl/bpbd_pkg.sv
rtl/bpbd_regs.sv
rtl/bpbd_blink.sv
rtl/bpbd_debounce.sv
rtl/blink_pattern_and_button_debounce.sv
bench/tb_top.sv
